[rtl/mfl_pkg.sv]
// shared constants, codes and control/status structs of the max flow unit
package mfl_pkg;

    localparam int NV       = 32;
    localparam int VW       = $clog2(NV);
    localparam int CAP_BITS = 16;
    localparam int RES_W    = CAP_BITS + 1;
    localparam int FLOW_W   = 22;
    localparam int ADDR_W   = 2 * VW;
    localparam int RAM_DEPTH = NV * NV;
    localparam int LVL_W    = VW + 1;
    localparam int QW       = LVL_W + VW;

    localparam logic [LVL_W-1:0]  UNREACHED = '1;
    localparam logic [RES_W-1:0]  RES_MAX   = '1;
    localparam logic [FLOW_W-1:0] FLOW_MAX  = '1;

    localparam logic OPC_ADD     = 1'b0;
    localparam logic OPC_COMPUTE = 1'b1;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_CMP_START,
        OP_BFS_INIT,
        OP_DEQ,
        OP_BFS_RD,
        OP_BFS_CHK,
        OP_PUSH_INIT,
        OP_DESCEND,
        OP_RETREAT,
        OP_AUG_INIT,
        OP_MIN_RD,
        OP_MIN_CHK,
        OP_UPD_INIT,
        OP_FWD_RD,
        OP_FWD_WR,
        OP_REV_RD,
        OP_REV_WR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } cmd_t;

    typedef struct packed {
        logic in_opcode;
        logic clr_last;
        logic src_eq_dst;
        logic q_empty;
        logic q_is_dst;
        logic u_last;
        logic top_is_dst;
        logic row_found;
        logic depth_zero;
        logic depth_max;
        logic idx_last;
        logic out_busy;
    } stat_t;

endpackage

[rtl/mfl_ram.sv]
// generic single write port ram with registered read
module mfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mfl_ctrl.sv]
// controller state machine of the max flow unit
module mfl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  mfl_pkg::stat_t stat,
    output mfl_pkg::cmd_t  cmd
);

    typedef enum logic [19:0] {
        ST_CLEAR     = 20'h00001,
        ST_IDLE      = 20'h00002,
        ST_ADD_RD    = 20'h00004,
        ST_ADD_WR    = 20'h00008,
        ST_CMP_START = 20'h00010,
        ST_BFS_INIT  = 20'h00020,
        ST_BFS_DEQ   = 20'h00040,
        ST_BFS_RD    = 20'h00080,
        ST_BFS_CHK   = 20'h00100,
        ST_PUSH_INIT = 20'h00200,
        ST_PUSH_TOP  = 20'h00400,
        ST_AUG_INIT  = 20'h00800,
        ST_MIN_RD    = 20'h01000,
        ST_MIN_CHK   = 20'h02000,
        ST_UPD_INIT  = 20'h04000,
        ST_FWD_RD    = 20'h08000,
        ST_FWD_WR    = 20'h10000,
        ST_REV_RD    = 20'h20000,
        ST_REV_WR    = 20'h40000,
        ST_FINISH    = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        cmd.op       = mfl_pkg::OP_NONE;
        cmd.in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = mfl_pkg::OP_CLEAR;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = mfl_pkg::OP_LOAD;
                    state_next = (stat.in_opcode == mfl_pkg::OPC_COMPUTE) ?
                                 ST_CMP_START : ST_ADD_RD;
                end
            end
            ST_ADD_RD: begin
                cmd.op = mfl_pkg::OP_ADD_RD;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                cmd.op = mfl_pkg::OP_ADD_WR;
                state_next = ST_IDLE;
            end
            ST_CMP_START: begin
                cmd.op = mfl_pkg::OP_CMP_START;
                state_next = stat.src_eq_dst ? ST_FINISH : ST_BFS_INIT;
            end
            ST_BFS_INIT: begin
                cmd.op = mfl_pkg::OP_BFS_INIT;
                state_next = ST_BFS_DEQ;
            end
            ST_BFS_DEQ: begin
                if (stat.q_empty) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.op = mfl_pkg::OP_DEQ;
                    state_next = stat.q_is_dst ? ST_PUSH_INIT : ST_BFS_RD;
                end
            end
            ST_BFS_RD: begin
                cmd.op = mfl_pkg::OP_BFS_RD;
                state_next = ST_BFS_CHK;
            end
            ST_BFS_CHK: begin
                cmd.op = mfl_pkg::OP_BFS_CHK;
                state_next = stat.u_last ? ST_BFS_DEQ : ST_BFS_RD;
            end
            ST_PUSH_INIT: begin
                cmd.op = mfl_pkg::OP_PUSH_INIT;
                state_next = ST_PUSH_TOP;
            end
            ST_PUSH_TOP: begin
                if (stat.top_is_dst) begin
                    state_next = ST_AUG_INIT;
                end else if (stat.row_found && !stat.depth_max) begin
                    cmd.op = mfl_pkg::OP_DESCEND;
                end else if (stat.depth_zero) begin
                    state_next = ST_BFS_INIT;
                end else begin
                    cmd.op = mfl_pkg::OP_RETREAT;
                end
            end
            ST_AUG_INIT: begin
                cmd.op = mfl_pkg::OP_AUG_INIT;
                state_next = ST_MIN_RD;
            end
            ST_MIN_RD: begin
                cmd.op = mfl_pkg::OP_MIN_RD;
                state_next = ST_MIN_CHK;
            end
            ST_MIN_CHK: begin
                cmd.op = mfl_pkg::OP_MIN_CHK;
                state_next = stat.idx_last ? ST_UPD_INIT : ST_MIN_RD;
            end
            ST_UPD_INIT: begin
                cmd.op = mfl_pkg::OP_UPD_INIT;
                state_next = ST_FWD_RD;
            end
            ST_FWD_RD: begin
                cmd.op = mfl_pkg::OP_FWD_RD;
                state_next = ST_FWD_WR;
            end
            ST_FWD_WR: begin
                cmd.op = mfl_pkg::OP_FWD_WR;
                state_next = ST_REV_RD;
            end
            ST_REV_RD: begin
                cmd.op = mfl_pkg::OP_REV_RD;
                state_next = ST_REV_WR;
            end
            ST_REV_WR: begin
                cmd.op = mfl_pkg::OP_REV_WR;
                state_next = stat.idx_last ? ST_PUSH_TOP : ST_FWD_RD;
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.op = mfl_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/mfl_dp.sv]
// datapath: residual matrix, layering queue, level rows, path stack, flow sum
module mfl_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mfl_pkg::cmd_t                   cmd,
    output mfl_pkg::stat_t                  stat,
    input  logic                            s_opcode,
    input  logic [mfl_pkg::VW-1:0]          s_from_vertex,
    input  logic [mfl_pkg::VW-1:0]          s_to_vertex,
    input  logic [mfl_pkg::CAP_BITS-1:0]    s_edge_capacity,
    input  logic [mfl_pkg::VW-1:0]          s_source_vertex,
    input  logic [mfl_pkg::VW-1:0]          s_target_vertex,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mfl_pkg::FLOW_W-1:0]      m_total_flow
);

    localparam int VW     = mfl_pkg::VW;
    localparam int NV     = mfl_pkg::NV;
    localparam int RES_W  = mfl_pkg::RES_W;
    localparam int LVL_W  = mfl_pkg::LVL_W;
    localparam int FLOW_W = mfl_pkg::FLOW_W;

    // captured item
    logic [VW-1:0]                from_reg, to_reg, src_reg, dst_reg;
    logic [mfl_pkg::CAP_BITS-1:0] cap_reg;

    logic [mfl_pkg::ADDR_W-1:0] clr_cnt_reg;

    // layering state
    logic [LVL_W-1:0]       level_reg [NV];
    logic [mfl_pkg::QW-1:0] queue_reg [NV];
    logic [VW:0]            head_reg, tail_reg;
    logic [VW-1:0]          v_reg, u_reg;
    logic [LVL_W-1:0]       lv_reg;
    logic [NV-1:0]          edge_row_reg [NV];

    // push state
    logic [VW-1:0]    stack_reg [NV];
    logic [VW-1:0]    depth_reg, idx_reg, top_reg, a_reg, b_reg;
    logic [RES_W-1:0] neck_reg;
    logic [FLOW_W-1:0] total_reg, out_total_reg;
    logic             out_valid_reg;

    // ram signals
    logic                       ram_we;
    logic [mfl_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [RES_W-1:0]           ram_wdata, ram_rdata;

    logic [VW-1:0]          stack_idx, stack_rd, first_u;
    logic [mfl_pkg::QW-1:0] qhead;
    logic [NV-1:0]          row;
    logic [LVL_W-1:0]       lu, lv_inc;
    logic [RES_W:0]         add_sum, rev_sum;
    logic [RES_W-1:0]       add_sat, rev_sat, fwd_diff;
    logic [FLOW_W:0]        flow_sum;
    logic [FLOW_W-1:0]      flow_sat;
    logic                   edge_ok;

    mfl_ram #(
        .WIDTH(RES_W),
        .DEPTH(mfl_pkg::RAM_DEPTH)
    ) u_res_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // single stack read port
    assign stack_idx = (cmd.op == mfl_pkg::OP_RETREAT) ? depth_reg - 1'b1 : idx_reg + 1'b1;
    assign stack_rd  = stack_reg[stack_idx];
    assign qhead     = queue_reg[head_reg[VW-1:0]];
    assign row       = edge_row_reg[top_reg];
    assign lu        = level_reg[u_reg];
    assign lv_inc    = lv_reg + 1'b1;
    assign edge_ok   = (ram_rdata != '0);

    // lowest-numbered level-graph edge out of the stack top
    always_comb begin
        first_u = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (row[i]) begin
                first_u = VW'(i);
            end
        end
    end

    // saturating sums and the forward residual difference
    assign add_sum  = {1'b0, ram_rdata} + (RES_W + 1)'(cap_reg);
    assign add_sat  = add_sum[RES_W] ? mfl_pkg::RES_MAX : add_sum[RES_W-1:0];
    assign rev_sum  = {1'b0, ram_rdata} + {1'b0, neck_reg};
    assign rev_sat  = rev_sum[RES_W] ? mfl_pkg::RES_MAX : rev_sum[RES_W-1:0];
    assign fwd_diff = ram_rdata - neck_reg;
    assign flow_sum = {1'b0, total_reg} + (FLOW_W + 1)'(neck_reg);
    assign flow_sat = flow_sum[FLOW_W] ? mfl_pkg::FLOW_MAX : flow_sum[FLOW_W-1:0];

    // residual ram access per operation
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {a_reg, b_reg};
        ram_wdata = '0;
        ram_raddr = {a_reg, stack_rd};
        case (cmd.op)
            mfl_pkg::OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            mfl_pkg::OP_ADD_RD: begin
                ram_raddr = {from_reg, to_reg};
            end
            mfl_pkg::OP_ADD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {from_reg, to_reg};
                ram_wdata = add_sat;
            end
            mfl_pkg::OP_BFS_RD: begin
                ram_raddr = {v_reg, u_reg};
            end
            mfl_pkg::OP_FWD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = fwd_diff;
            end
            mfl_pkg::OP_REV_RD: begin
                ram_raddr = {b_reg, a_reg};
            end
            mfl_pkg::OP_REV_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {b_reg, a_reg};
                ram_wdata = rev_sat;
            end
            default: begin
            end
        endcase
    end

    // status to the controller
    always_comb begin
        stat.in_opcode  = s_opcode;
        stat.clr_last   = (clr_cnt_reg == '1);
        stat.src_eq_dst = (src_reg == dst_reg);
        stat.q_empty    = (head_reg == tail_reg);
        stat.q_is_dst   = (qhead[VW-1:0] == dst_reg);
        stat.u_last     = (u_reg == '1);
        stat.top_is_dst = (top_reg == dst_reg);
        stat.row_found  = |row;
        stat.depth_zero = (depth_reg == '0);
        stat.depth_max  = (depth_reg == '1);
        stat.idx_last   = ((idx_reg + 1'b1) == depth_reg);
        stat.out_busy   = out_valid_reg && !m_ready;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == mfl_pkg::OP_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.op == mfl_pkg::OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and algorithm registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            mfl_pkg::OP_LOAD: begin
                from_reg <= s_from_vertex;
                to_reg   <= s_to_vertex;
                cap_reg  <= s_edge_capacity;
                src_reg  <= s_source_vertex;
                dst_reg  <= s_target_vertex;
            end
            mfl_pkg::OP_CMP_START: begin
                total_reg <= '0;
            end
            mfl_pkg::OP_BFS_INIT: begin
                // source at level zero, every other vertex unreached
                for (int i = 0; i < NV; i++) begin
                    level_reg[i]    <= (VW'(i) == src_reg) ? '0 : mfl_pkg::UNREACHED;
                    edge_row_reg[i] <= '0;
                end
                queue_reg[0]       <= {LVL_W'(0), src_reg};
                head_reg           <= '0;
                tail_reg           <= (VW + 1)'(1);
            end
            mfl_pkg::OP_DEQ: begin
                v_reg    <= qhead[VW-1:0];
                lv_reg   <= qhead[mfl_pkg::QW-1:VW];
                head_reg <= head_reg + 1'b1;
                u_reg    <= '0;
            end
            mfl_pkg::OP_BFS_CHK: begin
                if (edge_ok) begin
                    if (lu == mfl_pkg::UNREACHED) begin
                        level_reg[u_reg]            <= lv_inc;
                        queue_reg[tail_reg[VW-1:0]] <= {lv_inc, u_reg};
                        tail_reg                    <= tail_reg + 1'b1;
                    end
                    if (lu == mfl_pkg::UNREACHED || lu == lv_inc) begin
                        edge_row_reg[v_reg][u_reg] <= 1'b1;
                    end
                end
                u_reg <= u_reg + 1'b1;
            end
            mfl_pkg::OP_PUSH_INIT: begin
                depth_reg    <= '0;
                stack_reg[0] <= src_reg;
                top_reg      <= src_reg;
            end
            mfl_pkg::OP_DESCEND: begin
                stack_reg[depth_reg + 1'b1] <= first_u;
                depth_reg                   <= depth_reg + 1'b1;
                top_reg                     <= first_u;
            end
            mfl_pkg::OP_RETREAT: begin
                edge_row_reg[stack_rd][top_reg] <= 1'b0;
                top_reg                         <= stack_rd;
                depth_reg                       <= depth_reg - 1'b1;
            end
            mfl_pkg::OP_AUG_INIT: begin
                neck_reg <= mfl_pkg::RES_MAX;
                idx_reg  <= '0;
                a_reg    <= src_reg;
            end
            mfl_pkg::OP_MIN_RD, mfl_pkg::OP_FWD_RD: begin
                b_reg <= stack_rd;
            end
            mfl_pkg::OP_MIN_CHK: begin
                if (ram_rdata < neck_reg) begin
                    neck_reg <= ram_rdata;
                end
                a_reg   <= b_reg;
                idx_reg <= idx_reg + 1'b1;
            end
            mfl_pkg::OP_UPD_INIT: begin
                idx_reg   <= '0;
                a_reg     <= src_reg;
                total_reg <= flow_sat;
            end
            mfl_pkg::OP_FWD_WR: begin
                // a drained edge leaves the level graph
                if (fwd_diff == '0) begin
                    edge_row_reg[a_reg][b_reg] <= 1'b0;
                end
            end
            mfl_pkg::OP_REV_WR: begin
                a_reg   <= b_reg;
                idx_reg <= idx_reg + 1'b1;
                if (stat.idx_last) begin
                    depth_reg <= '0;
                    top_reg   <= src_reg;
                end
            end
            mfl_pkg::OP_EMIT: begin
                out_total_reg <= total_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = out_valid_reg;
    assign m_total_flow = out_total_reg;

endmodule

[rtl/max_flow_level_graph_unit.sv]
// top level of the max flow unit: controller plus datapath
// add-edge item: a residual read, then a saturating write back; no result.
// compute item: each layering round scans the edges out of every expanded vertex, then a
//   depth-first push descends and retreats, augmenting whenever the target is reached;
//   each augmentation updates both residuals; all matrix reads share one ram read port.
// throughput: one item at a time; a result waits only for the previous one to be taken.
// reset: synchronous active-low; a clearing pass first zeroes the whole residual ram.
module max_flow_level_graph_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [mfl_pkg::VW-1:0]        s_from_vertex,
    input  logic [mfl_pkg::VW-1:0]        s_to_vertex,
    input  logic [mfl_pkg::CAP_BITS-1:0]  s_edge_capacity,
    input  logic [mfl_pkg::VW-1:0]        s_source_vertex,
    input  logic [mfl_pkg::VW-1:0]        s_target_vertex,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mfl_pkg::FLOW_W-1:0]    m_total_flow
);

    mfl_pkg::cmd_t  cmd;
    mfl_pkg::stat_t stat;

    mfl_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .stat   (stat),
        .cmd    (cmd)
    );

    mfl_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_from_vertex  (s_from_vertex),
        .s_to_vertex    (s_to_vertex),
        .s_edge_capacity(s_edge_capacity),
        .s_source_vertex(s_source_vertex),
        .s_target_vertex(s_target_vertex),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_total_flow   (m_total_flow)
    );

    assign s_ready = cmd.in_ready;

endmodule

[rtl/mfl_checker.sv]
// port-level checker of the max flow unit and its bind
module mfl_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_opcode,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [mfl_pkg::FLOW_W-1:0] m_total_flow
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_flow))
        else $error("stalled result changed");

    // the unit is busy right after it takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an item");

    // an add-edge item never makes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == mfl_pkg::OPC_ADD) && !m_valid |=> !m_valid)
        else $error("add-edge item made a result");

    // a new result only appears after a busy cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

endmodule

bind max_flow_level_graph_unit mfl_checker u_mfl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_opcode    (s_opcode),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_total_flow(m_total_flow)
);

[tb/mfl_flow_checker.sv]
// channel monitor with flow predictor and result comparison for the max flow unit
`timescale 1ns / 1ps

module mfl_flow_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [mfl_pkg::VW-1:0]       s_from_vertex,
    input  logic [mfl_pkg::VW-1:0]       s_to_vertex,
    input  logic [mfl_pkg::CAP_BITS-1:0] s_edge_capacity,
    input  logic [mfl_pkg::VW-1:0]       s_source_vertex,
    input  logic [mfl_pkg::VW-1:0]       s_target_vertex,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [mfl_pkg::FLOW_W-1:0]   m_total_flow,
    output int                           fail_count,
    output int                           flows_pending
);

    localparam int NV     = mfl_pkg::NV;
    localparam int RES_W  = mfl_pkg::RES_W;
    localparam int LVL_W  = mfl_pkg::LVL_W;
    localparam int FLOW_W = mfl_pkg::FLOW_W;

    // shadow copy of the residual graph
    logic [RES_W-1:0] resid [NV][NV];
    bit               adj [NV][NV];
    bit               lvl_edge [NV][NV];
    logic [LVL_W-1:0] lvl [NV];
    int               path [NV];

    logic [FLOW_W-1:0] flow_q [$];

    // breadth-first layering, true when the sink is dequeued
    function automatic bit build_levels(int s, int t);
        int q [NV];
        int head, tail, v, u;
        head = 0;
        tail = 0;
        for (int a = 0; a < NV; a++) begin
            lvl[a] = mfl_pkg::UNREACHED;
            for (int b = 0; b < NV; b++) lvl_edge[a][b] = 0;
        end
        lvl[s] = '0;
        q[tail++] = s;
        while (head < tail) begin
            v = q[head++];
            if (v == t) return 1;
            for (u = 0; u < NV; u++) begin
                if (!adj[v][u] || resid[v][u] == 0) continue;
                if (lvl[u] == mfl_pkg::UNREACHED && tail < NV) begin
                    lvl[u] = lvl[v] + 1'b1;
                    q[tail++] = u;
                end
                if (lvl[u] == LVL_W'(lvl[v] + 1'b1)) lvl_edge[v][u] = 1;
            end
        end
        return 0;
    endfunction

    // depth-first blocking flow along layer edges
    function automatic longint push_blocking(int s, int t);
        longint pushed, neck, r;
        int depth, v, u, a, b;
        pushed = 0;
        depth = 0;
        path[0] = s;
        forever begin
            v = path[depth];
            if (v == t) begin
                neck = mfl_pkg::RES_MAX;
                for (int i = 0; i < depth; i++) begin
                    r = resid[path[i]][path[i+1]];
                    if (r < neck) neck = r;
                end
                for (int i = 0; i < depth; i++) begin
                    a = path[i];
                    b = path[i+1];
                    resid[a][b] = resid[a][b] - RES_W'(neck);
                    r = longint'(resid[b][a]) + neck;
                    resid[b][a] = (r > mfl_pkg::RES_MAX) ? mfl_pkg::RES_MAX : RES_W'(r);
                end
                pushed += neck;
                depth = 0;
                continue;
            end
            for (u = 0; u < NV; u++)
                if (lvl_edge[v][u] && resid[v][u] > 0) break;
            if (u < NV && depth + 1 < NV) begin
                depth++;
                path[depth] = u;
            end else begin
                if (depth == 0) return pushed;
                lvl_edge[path[depth-1]][v] = 0;
                depth--;
            end
        end
    endfunction

    function automatic logic [FLOW_W-1:0] predict_flow(int s, int t);
        longint total;
        total = 0;
        if (s != t) begin
            while (build_levels(s, t)) begin
                total += push_blocking(s, t);
                if (total > mfl_pkg::FLOW_MAX) total = mfl_pkg::FLOW_MAX;
            end
        end
        return FLOW_W'(total);
    endfunction

    // predict on accepted input items, compare accepted results
    always @(posedge aclk) begin
        logic [FLOW_W-1:0] want;
        longint sum;
        if (!aresetn) begin
            for (int a = 0; a < NV; a++) begin
                lvl[a] = mfl_pkg::UNREACHED;
                for (int b = 0; b < NV; b++) begin
                    resid[a][b] = '0;
                    adj[a][b] = 0;
                    lvl_edge[a][b] = 0;
                end
            end
            flow_q.delete();
            fail_count    <= 0;
            flows_pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_opcode == mfl_pkg::OPC_ADD) begin
                    sum = longint'(resid[s_from_vertex][s_to_vertex]) + s_edge_capacity;
                    resid[s_from_vertex][s_to_vertex] = (sum > mfl_pkg::RES_MAX)
                                                        ? mfl_pkg::RES_MAX : RES_W'(sum);
                    adj[s_from_vertex][s_to_vertex] = 1;
                    adj[s_to_vertex][s_from_vertex] = 1;
                end else begin
                    flow_q = {flow_q, predict_flow(s_source_vertex, s_target_vertex)};
                end
            end
            if (m_valid && m_ready) begin
                if (flow_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: total_flow %0d", m_total_flow);
                    fail_count <= fail_count + 1;
                end else begin
                    want = flow_q.pop_front();
                    if (want !== m_total_flow) begin
                        if (fail_count < 10)
                            $display("total_flow mismatch: expected %0d actual %0d",
                                     want, m_total_flow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            flows_pending <= flow_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// stimulus, clocking and verdict for the max flow unit testbench
`timescale 1ns / 1ps

module tb_top;

    localparam int VW          = mfl_pkg::VW;
    localparam int CAP_BITS    = mfl_pkg::CAP_BITS;
    localparam int FLOW_W      = mfl_pkg::FLOW_W;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int HOLD_CYCLES = 3000;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    logic              s_opcode = mfl_pkg::OPC_ADD;
    logic [VW-1:0]     s_from_vertex = '0;
    logic [VW-1:0]     s_to_vertex = '0;
    logic [CAP_BITS-1:0] s_edge_capacity = '0;
    logic [VW-1:0]     s_source_vertex = '0;
    logic [VW-1:0]     s_target_vertex = '0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [FLOW_W-1:0] m_total_flow;

    int  fail_count;
    int  flows_pending;
    int  cycle_cnt = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  burst_left = 0;

    always #4 aclk = ~aclk;

    max_flow_level_graph_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_from_vertex(s_from_vertex), .s_to_vertex(s_to_vertex),
        .s_edge_capacity(s_edge_capacity), .s_source_vertex(s_source_vertex),
        .s_target_vertex(s_target_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_total_flow(m_total_flow)
    );

    mfl_flow_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_from_vertex(s_from_vertex), .s_to_vertex(s_to_vertex),
        .s_edge_capacity(s_edge_capacity), .s_source_vertex(s_source_vertex),
        .s_target_vertex(s_target_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_total_flow(m_total_flow),
        .fail_count(fail_count), .flows_pending(flows_pending)
    );

    // run watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                m_ready <= 0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge aclk);
            end
            case (cycle_cnt[11:10])
                2'd0: m_ready <= 1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= cycle_cnt[3];
            endcase
        end
    end

    // drive one item at the falling edge and hold it until accepted
    task automatic send_item(logic opc, int fv, int tv, int cap, int sv, int tgt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid         <= 1;
        s_opcode        <= opc;
        s_from_vertex   <= VW'(fv);
        s_to_vertex     <= VW'(tv);
        s_edge_capacity <= CAP_BITS'(cap);
        s_source_vertex <= VW'(sv);
        s_target_vertex <= VW'(tgt);
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic add_edge(int fv, int tv, int cap);
        send_item(mfl_pkg::OPC_ADD, fv, tv, cap, $urandom_range(0, 31), $urandom_range(0, 31));
    endtask

    task automatic ask_flow(int sv, int tgt);
        send_item(mfl_pkg::OPC_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 65535), sv, tgt);
    endtask

    initial begin
        int base, n, sv, tgt;
        repeat (12) @(negedge aclk);
        aresetn <= 1;

        // directed: extremes, saturation, self loop, source equal to target
        add_edge(0, 31, 65535);
        add_edge(0, 31, 65535);
        add_edge(0, 31, 65535);
        ask_flow(0, 31);
        ask_flow(31, 0);
        add_edge(5, 5, 1234);
        ask_flow(5, 5);
        add_edge(1, 2, 0);
        ask_flow(1, 2);
        add_edge(1, 2, 7);
        add_edge(2, 3, 5);
        add_edge(1, 3, 4);
        add_edge(3, 1, 9);
        ask_flow(1, 3);
        ask_flow(1, 3);
        ask_flow(3, 1);
        add_edge(31, 30, 65535);
        add_edge(30, 29, 1);
        ask_flow(31, 29);
        ask_flow(10, 11);
        ask_flow(0, 0);
        ask_flow(31, 31);

        // random: small subgraphs built then queried, plus noise
        n = 0;
        while (n < 500) begin
            if (n >= 120) hold_req = 1;
            if ($urandom_range(0, 9) == 0) begin
                // scattered noise across the whole vertex range
                if ($urandom_range(0, 1)) add_edge($urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535));
                else ask_flow($urandom_range(0, 31), $urandom_range(0, 31));
                n++;
            end else begin
                base = $urandom_range(0, 3) * 8;
                repeat ($urandom_range(2, 7)) begin
                    add_edge(base + $urandom_range(0, 7), base + $urandom_range(0, 7),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 300));
                    n++;
                end
                sv  = base + $urandom_range(0, 7);
                tgt = base + $urandom_range(0, 7);
                ask_flow(sv, tgt);
                n++;
            end
        end
        @(negedge aclk);
        s_valid <= 0;

        // drain outstanding results and let the block settle
        while (flows_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[max_flow_level_graph_unit.f]
rtl/mfl_pkg.sv
rtl/mfl_ram.sv
rtl/mfl_ctrl.sv
rtl/mfl_dp.sv
rtl/max_flow_level_graph_unit.sv
rtl/mfl_checker.sv
tb/mfl_flow_checker.sv
tb/tb_top.sv
